// ===== sv/pdps_pkg.sv =====
// ----------------------------------------------------------------------------
// pdps_pkg: shared types and constants of the peak detector with box sum
// Request and command codes, the command word that crosses the queue and
// the result word delivered at the output.
// ----------------------------------------------------------------------------
package pdps_pkg;

  localparam int WINDOW_LEN_DEF  = 5;
  localparam int PEAK_SLOTS_DEF  = 64;
  localparam int CMD_QUEUE_DEPTH = 4;

  localparam int DEPTH_W  = 16;
  localparam int SCORE_W  = 16;
  localparam int PSCORE_W = 15;
  localparam int SUM_W    = 21;
  localparam int CFG_W    = 15;

  localparam logic [CFG_W-1:0] THRESHOLD_RST  = 15'd8192;
  localparam logic [CFG_W-1:0] HALF_WIDTH_RST = 15'd256;

  typedef enum logic {
    REG_PEAK_THRESHOLD    = 1'b0,
    REG_WINDOW_HALF_WIDTH = 1'b1
  } reg_idx_t;

  typedef enum logic [1:0] {
    REQ_LINE_START = 2'd0,
    REQ_PUSH       = 2'd1,
    REQ_QUERY      = 2'd2,
    REQ_CLEAR      = 2'd3
  } req_t;

  typedef enum logic [1:0] {
    CMD_ZERO  = 2'd0,
    CMD_STORE = 2'd1,
    CMD_QUERY = 2'd2,
    CMD_CLEAR = 2'd3
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t                   kind;
    logic signed [DEPTH_W-1:0]   depth;
    logic        [PSCORE_W-1:0]  score;
  } cmd_t;

  typedef struct packed {
    logic                        peak_found;
    logic signed [DEPTH_W-1:0]   peak_depth;
    logic        [PSCORE_W-1:0]  peak_score;
    logic        [SUM_W-1:0]     sum_score;
    logic                        store_full;
  } res_t;

  typedef enum logic [1:0] {
    BK_IDLE = 2'd0,
    BK_SCAN = 2'd1,
    BK_DONE = 2'd2
  } bk_state_t;

endpackage

// ===== sv/pdps_ram.sv =====
// ----------------------------------------------------------------------------
// pdps_ram: generic single write port RAM
// One write and one read port, read data registered.
// ----------------------------------------------------------------------------
module pdps_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== sv/pdps_front.sv =====
// ----------------------------------------------------------------------------
// pdps_front: request intake and sample window
// Keeps the sliding window of the current line, tests its centre for a
// peak and turns every request into one command word for the back end.
// ----------------------------------------------------------------------------
module pdps_front #(
  parameter int WINDOW_LEN = pdps_pkg::WINDOW_LEN_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  pdps_pkg::req_t                        in_req,
  input  logic signed [pdps_pkg::DEPTH_W-1:0]   in_depth,
  input  logic signed [pdps_pkg::SCORE_W-1:0]   in_score,
  input  logic        [pdps_pkg::CFG_W-1:0]     threshold,
  output logic                                  cmd_valid,
  input  logic                                  cmd_ready,
  output pdps_pkg::cmd_t                        cmd
);

  import pdps_pkg::*;

  localparam int FW     = $clog2(WINDOW_LEN + 1);
  localparam int CENTRE = WINDOW_LEN / 2;

  logic signed [DEPTH_W-1:0] win_depth_r [WINDOW_LEN];
  logic signed [SCORE_W-1:0] win_score_r [WINDOW_LEN];
  logic signed [DEPTH_W-1:0] win_depth_nxt [WINDOW_LEN];
  logic signed [SCORE_W-1:0] win_score_nxt [WINDOW_LEN];
  logic [FW-1:0]             fill_r, fill_nxt;
  logic                      accept;
  logic                      full_nxt;
  logic                      is_peak;
  logic signed [SCORE_W-1:0] centre_score;

  assign in_ready  = cmd_ready;
  assign cmd_valid = in_valid;
  assign accept    = in_valid && cmd_ready;

  // new sample always enters at the top; once full the order matches arrival
  always_comb begin
    for (int i = 0; i < WINDOW_LEN - 1; i++) begin
      win_depth_nxt[i] = win_depth_r[i+1];
      win_score_nxt[i] = win_score_r[i+1];
    end
    win_depth_nxt[WINDOW_LEN-1] = in_depth;
    win_score_nxt[WINDOW_LEN-1] = in_score;
  end

  assign full_nxt     = (fill_r >= FW'(WINDOW_LEN - 1));
  assign centre_score = win_score_nxt[CENTRE];

  always_comb begin
    is_peak = full_nxt &&
              ($signed({centre_score[SCORE_W-1], centre_score}) >
               $signed({2'b00, threshold}));
    for (int i = 0; i < WINDOW_LEN; i++) begin
      if (centre_score < win_score_nxt[i]) begin
        is_peak = 1'b0;
      end
    end
  end

  always_comb begin
    fill_nxt  = fill_r;
    cmd.kind  = CMD_ZERO;
    cmd.depth = in_depth;
    cmd.score = centre_score[PSCORE_W-1:0];
    case (in_req)
      REQ_LINE_START: begin
        fill_nxt = '0;
      end
      REQ_PUSH: begin
        if (fill_r != FW'(WINDOW_LEN)) begin
          fill_nxt = fill_r + 1'b1;
        end
        if (is_peak) begin
          cmd.kind  = CMD_STORE;
          cmd.depth = win_depth_nxt[CENTRE];
        end
      end
      REQ_QUERY: begin
        cmd.kind = CMD_QUERY;
      end
      REQ_CLEAR: begin
        cmd.kind = CMD_CLEAR;
      end
      default: begin
        cmd.kind = CMD_ZERO;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r <= '0;
    end else if (accept) begin
      fill_r <= fill_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && in_req == REQ_PUSH) begin
      for (int i = 0; i < WINDOW_LEN; i++) begin
        win_depth_r[i] <= win_depth_nxt[i];
        win_score_r[i] <= win_score_nxt[i];
      end
    end
  end

endmodule

// ===== sv/pdps_queue.sv =====
// ----------------------------------------------------------------------------
// pdps_queue: command queue between front and back end
// Small register FIFO so intake keeps going while a query walks the store.
// ----------------------------------------------------------------------------
module pdps_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           wr_valid,
  output logic           wr_ready,
  input  pdps_pkg::cmd_t wr_data,
  output logic           rd_valid,
  input  logic           rd_ready,
  output pdps_pkg::cmd_t rd_data
);

  import pdps_pkg::*;

  localparam int QD = CMD_QUEUE_DEPTH;
  localparam int PW = $clog2(QD);
  localparam int CW = $clog2(QD + 1);

  cmd_t          mem_r [QD];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          do_wr, do_rd;

  assign wr_ready = (cnt_r != CW'(QD));
  assign rd_valid = (cnt_r != '0);
  assign rd_data  = mem_r[rd_ptr_r];
  assign do_wr    = wr_valid && wr_ready;
  assign do_rd    = rd_valid && rd_ready;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_wr) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(QD - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_rd) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(QD - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_wr && !do_rd) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_rd && !do_wr) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

endmodule

// ===== sv/pdps_back.sv =====
// ----------------------------------------------------------------------------
// pdps_back: peak store and score sum
// Executes commands from the queue: stores peaks, clears the store and
// walks the stored peaks one per cycle to form the box window sum.
// ----------------------------------------------------------------------------
module pdps_back #(
  parameter int PEAK_SLOTS = pdps_pkg::PEAK_SLOTS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cmd_valid,
  output logic                          cmd_ready,
  input  pdps_pkg::cmd_t                cmd,
  input  logic [pdps_pkg::CFG_W-1:0]    half_width,
  output logic                          res_valid,
  input  logic                          res_ready,
  output pdps_pkg::res_t                res
);

  import pdps_pkg::*;

  localparam int AW = $clog2(PEAK_SLOTS);
  localparam int CW = $clog2(PEAK_SLOTS + 1);
  localparam int RW = DEPTH_W + PSCORE_W;

  bk_state_t                 state_r, state_nxt;
  logic [CW-1:0]             count_r, count_nxt;
  logic [CW-1:0]             rd_idx_r, rd_idx_nxt;
  logic                      rd_vld_r, rd_vld_nxt;
  logic signed [DEPTH_W-1:0] qdepth_r, qdepth_nxt;
  logic [SUM_W-1:0]          acc_r, acc_nxt;
  logic                      res_valid_r, res_valid_nxt;
  res_t                      res_r, res_nxt;

  logic                      out_free;
  logic                      pop;
  logic                      scan_done;
  logic                      ram_we, ram_re;
  logic [RW-1:0]             ram_rdata;
  logic signed [DEPTH_W-1:0] peak_d;
  logic [PSCORE_W-1:0]       peak_s;
  logic signed [DEPTH_W:0]   diff;
  logic [DEPTH_W:0]          abs_diff;
  logic [SUM_W:0]            sum_wide;

  assign out_free  = !res_valid_r || res_ready;
  assign pop       = (state_r == BK_IDLE) && cmd_valid && out_free;
  assign ram_re    = (state_r == BK_SCAN) && (rd_idx_r < count_r);
  assign scan_done = (state_r == BK_SCAN) && !ram_re && !rd_vld_r;
  assign ram_we    = pop && (cmd.kind == CMD_STORE) && (count_r < CW'(PEAK_SLOTS));
  assign cmd_ready = pop;
  assign res_valid = res_valid_r;
  assign res       = res_r;

  pdps_ram #(
    .WIDTH (RW),
    .DEPTH (PEAK_SLOTS)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (count_r[AW-1:0]),
    .wdata ({cmd.depth, cmd.score}),
    .re    (ram_re),
    .raddr (rd_idx_r[AW-1:0]),
    .rdata (ram_rdata)
  );

  assign peak_d   = ram_rdata[RW-1:PSCORE_W];
  assign peak_s   = ram_rdata[PSCORE_W-1:0];
  assign diff     = {qdepth_r[DEPTH_W-1], qdepth_r} - {peak_d[DEPTH_W-1], peak_d};
  assign abs_diff = diff[DEPTH_W] ? (DEPTH_W+1)'(-diff) : diff;
  assign sum_wide = {1'b0, acc_r} + (SUM_W+1)'(peak_s);

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      BK_IDLE: begin
        if (pop && cmd.kind == CMD_QUERY) begin
          state_nxt = BK_SCAN;
        end
      end
      BK_SCAN: begin
        if (scan_done) begin
          state_nxt = BK_DONE;
        end
      end
      BK_DONE: begin
        if (out_free) begin
          state_nxt = BK_IDLE;
        end
      end
      default: begin
        state_nxt = BK_IDLE;
      end
    endcase
  end

  // datapath and outputs
  always_comb begin
    count_nxt     = count_r;
    rd_idx_nxt    = rd_idx_r;
    rd_vld_nxt    = 1'b0;
    qdepth_nxt    = qdepth_r;
    acc_nxt       = acc_r;
    res_valid_nxt = res_valid_r && !res_ready;
    res_nxt       = res_r;
    case (state_r)
      BK_IDLE: begin
        if (pop) begin
          res_nxt = '0;
          case (cmd.kind)
            CMD_STORE: begin
              res_valid_nxt = 1'b1;
              if (count_r < CW'(PEAK_SLOTS)) begin
                count_nxt          = count_r + 1'b1;
                res_nxt.peak_found = 1'b1;
                res_nxt.peak_depth = cmd.depth;
                res_nxt.peak_score = cmd.score;
              end else begin
                res_nxt.store_full = 1'b1;
              end
            end
            CMD_QUERY: begin
              res_nxt    = res_r;
              qdepth_nxt = cmd.depth;
              acc_nxt    = '0;
              rd_idx_nxt = '0;
            end
            CMD_CLEAR: begin
              count_nxt     = '0;
              res_valid_nxt = 1'b1;
            end
            default: begin
              res_valid_nxt = 1'b1;
            end
          endcase
        end
      end
      BK_SCAN: begin
        if (ram_re) begin
          rd_idx_nxt = rd_idx_r + 1'b1;
          rd_vld_nxt = 1'b1;
        end
        if (rd_vld_r && abs_diff <= (DEPTH_W+1)'(half_width)) begin
          // saturate the running sum
          acc_nxt = sum_wide[SUM_W] ? {SUM_W{1'b1}} : sum_wide[SUM_W-1:0];
        end
      end
      BK_DONE: begin
        if (out_free) begin
          res_valid_nxt     = 1'b1;
          res_nxt           = '0;
          res_nxt.sum_score = acc_r;
        end
      end
      default: begin
        rd_vld_nxt = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BK_IDLE;
      count_r     <= '0;
      rd_vld_r    <= 1'b0;
      res_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      rd_vld_r    <= rd_vld_nxt;
      res_valid_r <= res_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rd_idx_r <= rd_idx_nxt;
    qdepth_r <= qdepth_nxt;
    acc_r    <= acc_nxt;
    res_r    <= res_nxt;
  end

endmodule

// ===== sv/peak_detect_parzen_score.sv =====
// ----------------------------------------------------------------------------
// peak_detect_parzen_score: window peak detector with box Parzen score sum
// Streams depth/score samples of a line, stores local peaks and answers
// box window score queries over the stored peaks.
// ----------------------------------------------------------------------------
// Every request word returns exactly one result word, in order. Line start,
// push and clear words are taken one per cycle into a small command queue
// and leave the back end one per cycle; each request word is registered in
// the command queue and its result word then in the output register. A score
// query walks the peak store through its single registered read port, one
// stored peak per cycle; words behind it queue up and intake stalls once the
// queue is full. A result word waiting in the output register holds the back
// end until it is taken; a query walk already under way runs on regardless.
// Configuration is taken in any cycle and must only be written while idle.
module peak_detect_parzen_score #(
  parameter int WINDOW_LEN = pdps_pkg::WINDOW_LEN_DEF,
  parameter int PEAK_SLOTS = pdps_pkg::PEAK_SLOTS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [31:0]                   in_tdata,   // depth[15:0], score[31:16]
  input  logic [1:0]                    in_tuser,   // req_type[1:0]
  output logic                          out_tvalid,
  input  logic                          out_tready,
  // peak_depth[15:0], peak_score[30:16], sum_score[51:31], zero pad[55:52]
  output logic [55:0]                   out_tdata,
  output logic [1:0]                    out_tuser,  // peak_found[0], store_full[1]
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic                          cfg_index,
  input  logic [pdps_pkg::CFG_W-1:0]    cfg_data
);

  import pdps_pkg::*;

  logic [CFG_W-1:0] threshold_r;
  logic [CFG_W-1:0] half_width_r;
  logic             fq_valid, fq_ready;
  cmd_t             fq_cmd;
  logic             qb_valid, qb_ready;
  cmd_t             qb_cmd;
  res_t             res;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      threshold_r  <= THRESHOLD_RST;
      half_width_r <= HALF_WIDTH_RST;
    end else if (cfg_valid) begin
      case (reg_idx_t'(cfg_index))
        REG_PEAK_THRESHOLD:    threshold_r  <= cfg_data;
        REG_WINDOW_HALF_WIDTH: half_width_r <= cfg_data;
        default:               threshold_r  <= threshold_r;
      endcase
    end
  end

  pdps_front #(
    .WINDOW_LEN (WINDOW_LEN)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .in_req    (req_t'(in_tuser)),
    .in_depth  ($signed(in_tdata[15:0])),
    .in_score  ($signed(in_tdata[31:16])),
    .threshold (threshold_r),
    .cmd_valid (fq_valid),
    .cmd_ready (fq_ready),
    .cmd       (fq_cmd)
  );

  pdps_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_valid (fq_valid),
    .wr_ready (fq_ready),
    .wr_data  (fq_cmd),
    .rd_valid (qb_valid),
    .rd_ready (qb_ready),
    .rd_data  (qb_cmd)
  );

  pdps_back #(
    .PEAK_SLOTS (PEAK_SLOTS)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd_valid  (qb_valid),
    .cmd_ready  (qb_ready),
    .cmd        (qb_cmd),
    .half_width (half_width_r),
    .res_valid  (out_tvalid),
    .res_ready  (out_tready),
    .res        (res)
  );

  assign out_tdata = {4'b0000, res.sum_score, res.peak_score, res.peak_depth};
  assign out_tuser = {res.store_full, res.peak_found};

endmodule
